@@ sv/mac_pkg.sv @@
// shared types, constants and sizes of the moving average crossover block
package mac_pkg;

  // sizing of the price history
  localparam int MAX_WINDOW  = 64;
  localparam int PRICE_BITS  = 32;
  localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
  localparam int PERIOD_BITS = $clog2(MAX_WINDOW + 1);
  localparam int SUM_BITS    = PRICE_BITS + $clog2(MAX_WINDOW);
  localparam int PROD_BITS   = SUM_BITS + PERIOD_BITS;

  // fixed field widths
  localparam int SYMBOL_BITS = 16;
  localparam int FIELD_BITS  = 32;
  localparam int CFG_PERIOD_BITS = 7;
  localparam int CMP_BITS    = (PERIOD_BITS > CFG_PERIOD_BITS) ? PERIOD_BITS : CFG_PERIOD_BITS;

  // configuration port
  localparam int ADDR_BITS = 4;
  localparam int DATA_BITS = 32;

  // result queue
  localparam int QUEUE_DEPTH    = 4;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int OCC_BITS       = $clog2(QUEUE_DEPTH + 1);

  // register reset values
  localparam logic [SYMBOL_BITS-1:0]     SYMBOL_RESET = '0;
  localparam logic [CFG_PERIOD_BITS-1:0] SHORT_RESET  = CFG_PERIOD_BITS'(5);
  localparam logic [CFG_PERIOD_BITS-1:0] LONG_RESET   = CFG_PERIOD_BITS'(20);

  // register indexes
  typedef enum logic [1:0] {
    REG_SYMBOL = 2'd0,
    REG_SHORT  = 2'd1,
    REG_LONG   = 2'd2
  } reg_index_t;

  // order sides
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // one queued order
  typedef struct packed {
    logic                  side;
    logic [FIELD_BITS-1:0] price;
  } order_t;

endpackage

@@ sv/mac_tick_if.sv @@
// market tick channel
interface mac_tick_if;
  logic                               valid;
  logic                               ready;
  logic [mac_pkg::SYMBOL_BITS-1:0]    symbol_id;
  logic [mac_pkg::FIELD_BITS-1:0]     last_price;
  logic [mac_pkg::FIELD_BITS-1:0]     bid_price;
  logic [mac_pkg::FIELD_BITS-1:0]     ask_price;

  modport source (output valid, output symbol_id, output last_price, output bid_price,
                  output ask_price, input ready);
  modport sink   (input valid, input symbol_id, input last_price, input bid_price,
                  input ask_price, output ready);
endinterface

@@ sv/mac_order_if.sv @@
// order channel
interface mac_order_if;
  logic                           valid;
  logic                           ready;
  logic                           order_side;
  logic [mac_pkg::FIELD_BITS-1:0] order_price;

  modport source (output valid, output order_side, output order_price, input ready);
  modport sink   (input valid, input order_side, input order_price, output ready);
endinterface

@@ sv/moving_average_crossover.sv @@
// moving average crossover signal generator, top level
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  tick    | in  | valid/ready          | symbol_id, last_price, bid_price, ask_price
//  order   | out | valid/ready          | order_side, order_price
//  apb     | in  | psel/penable, pready | paddr, pwdata, prdata (3 registers)
//
// the price ring has one read port: each tick reads the oldest price of the long
// window in phase zero and of the short window in phase one, and the next tick may
// be taken in phase one. an order passes the short sum, multiply and compare stages.
// reset is synchronous; the ring itself is not cleared, the fill count guards it.
// up to 4 ticks may be in flight or queued as orders; the tick input waits beyond that.
module moving_average_crossover (
  input  logic                            clk,
  input  logic                            rst,
  mac_tick_if.sink                        tick,
  mac_order_if.source                     order,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [mac_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [mac_pkg::DATA_BITS-1:0]   pwdata,
  output logic [mac_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready
);

  // configuration registers
  logic [mac_pkg::SYMBOL_BITS-1:0]     tracked_symbol;
  logic [mac_pkg::CFG_PERIOD_BITS-1:0] short_period;
  logic [mac_pkg::CFG_PERIOD_BITS-1:0] long_period;

  // history state
  logic [mac_pkg::PRICE_BITS-1:0]  ring [mac_pkg::MAX_WINDOW];
  logic [mac_pkg::PRICE_BITS-1:0]  ring_rdata;
  logic [mac_pkg::SLOT_BITS-1:0]   ring_raddr;
  logic                            ring_we;
  logic [mac_pkg::PERIOD_BITS-1:0] fill_count;
  logic [mac_pkg::PERIOD_BITS-1:0] fill_count_next;
  logic [mac_pkg::SLOT_BITS-1:0]   write_slot;
  logic [mac_pkg::SUM_BITS-1:0]    short_window_sum;
  logic [mac_pkg::SUM_BITS-1:0]    short_window_sum_next;
  logic [mac_pkg::SUM_BITS-1:0]    long_window_sum;
  logic [mac_pkg::SUM_BITS-1:0]    long_window_sum_next;
  logic                            was_above;

  // tick register, two phases per tick
  logic                            core_valid;
  logic                            core_phase;
  logic                            core_match;
  logic [mac_pkg::PRICE_BITS-1:0]  core_price;
  logic [mac_pkg::FIELD_BITS-1:0]  core_bid;
  logic [mac_pkg::FIELD_BITS-1:0]  core_ask;

  // short sum stage
  logic                            s2_valid;
  logic                            s2_match;
  logic                            s2_sub;
  logic                            s2_full;
  logic [mac_pkg::PRICE_BITS-1:0]  s2_price;
  logic [mac_pkg::FIELD_BITS-1:0]  s2_bid;
  logic [mac_pkg::FIELD_BITS-1:0]  s2_ask;

  // multiply stage
  logic                            s3_valid;
  logic                            s3_go;
  logic [mac_pkg::SUM_BITS-1:0]    s3_short;
  logic [mac_pkg::SUM_BITS-1:0]    s3_long;
  logic [mac_pkg::FIELD_BITS-1:0]  s3_bid;
  logic [mac_pkg::FIELD_BITS-1:0]  s3_ask;

  // compare stage
  logic                            s4_valid;
  logic                            s4_go;
  logic [mac_pkg::PROD_BITS-1:0]   s4_prod_short;
  logic [mac_pkg::PROD_BITS-1:0]   s4_prod_long;
  logic [mac_pkg::FIELD_BITS-1:0]  s4_bid;
  logic [mac_pkg::FIELD_BITS-1:0]  s4_ask;
  logic                            above;
  logic                            emit;
  mac_pkg::order_t                 emit_order;

  // order queue
  mac_pkg::order_t                   queue [mac_pkg::QUEUE_DEPTH];
  logic [mac_pkg::QUEUE_PTR_BITS-1:0] queue_head;
  logic [mac_pkg::QUEUE_PTR_BITS-1:0] queue_tail;
  logic [mac_pkg::OCC_BITS-1:0]       queue_count;
  logic [mac_pkg::OCC_BITS-1:0]       occupancy;
  logic                               pop;
  logic                               drop;

  // effective periods
  logic [mac_pkg::CMP_BITS-1:0]    lp_wide;
  logic [mac_pkg::CMP_BITS-1:0]    sp_wide;
  logic [mac_pkg::PERIOD_BITS-1:0] lp;
  logic [mac_pkg::PERIOD_BITS-1:0] sp;
  logic [mac_pkg::PERIOD_BITS-1:0] slot_ext;
  logic [mac_pkg::SLOT_BITS-1:0]   long_addr;
  logic [mac_pkg::SLOT_BITS-1:0]   short_addr;

  logic cfg_write;
  logic cfg_clear;
  logic tick_accept;
  logic core_free;

  // clamp the periods into range
  always_comb begin
    lp_wide = mac_pkg::CMP_BITS'(long_period);
    if (lp_wide == '0) begin
      lp_wide = mac_pkg::CMP_BITS'(1);
    end else if (lp_wide > mac_pkg::CMP_BITS'(mac_pkg::MAX_WINDOW)) begin
      lp_wide = mac_pkg::CMP_BITS'(mac_pkg::MAX_WINDOW);
    end
    sp_wide = mac_pkg::CMP_BITS'(short_period);
    if (sp_wide == '0) begin
      sp_wide = mac_pkg::CMP_BITS'(1);
    end else if (sp_wide > lp_wide) begin
      sp_wide = lp_wide;
    end
    lp = mac_pkg::PERIOD_BITS'(lp_wide);
    sp = mac_pkg::PERIOD_BITS'(sp_wide);
  end

  // ring addresses of the oldest prices in each window
  always_comb begin
    slot_ext = mac_pkg::PERIOD_BITS'(write_slot);
    if (slot_ext >= lp) begin
      long_addr = mac_pkg::SLOT_BITS'(slot_ext - lp);
    end else begin
      long_addr = mac_pkg::SLOT_BITS'(slot_ext + mac_pkg::PERIOD_BITS'(mac_pkg::MAX_WINDOW) - lp);
    end
    if (slot_ext >= sp) begin
      short_addr = mac_pkg::SLOT_BITS'(slot_ext - sp);
    end else begin
      short_addr = mac_pkg::SLOT_BITS'(slot_ext + mac_pkg::PERIOD_BITS'(mac_pkg::MAX_WINDOW) - sp);
    end
  end

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // only a write to one of the three registers restarts the history
  assign cfg_clear = cfg_write && (paddr[3:2] inside {mac_pkg::REG_SYMBOL, mac_pkg::REG_SHORT,
                                                     mac_pkg::REG_LONG});

  always_comb begin
    unique case (paddr[3:2])
      mac_pkg::REG_SYMBOL: prdata = mac_pkg::DATA_BITS'(tracked_symbol);
      mac_pkg::REG_SHORT:  prdata = mac_pkg::DATA_BITS'(short_period);
      mac_pkg::REG_LONG:   prdata = mac_pkg::DATA_BITS'(long_period);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tracked_symbol <= mac_pkg::SYMBOL_RESET;
      short_period   <= mac_pkg::SHORT_RESET;
      long_period    <= mac_pkg::LONG_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        mac_pkg::REG_SYMBOL: tracked_symbol <= pwdata[mac_pkg::SYMBOL_BITS-1:0];
        mac_pkg::REG_SHORT:  short_period   <= pwdata[mac_pkg::CFG_PERIOD_BITS-1:0];
        mac_pkg::REG_LONG:   long_period    <= pwdata[mac_pkg::CFG_PERIOD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // tick intake: core frees up after phase one, room is reserved for the order
  assign core_free   = !core_valid || core_phase;
  assign tick.ready  = core_free && (occupancy < mac_pkg::OCC_BITS'(mac_pkg::QUEUE_DEPTH));
  assign tick_accept = tick.valid && tick.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      core_valid <= 1'b0;
      core_phase <= 1'b0;
    end else if (tick_accept) begin
      core_valid <= 1'b1;
      core_phase <= 1'b0;
    end else if (core_valid) begin
      core_valid <= !core_phase;
      core_phase <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_accept) begin
      core_match <= (tick.symbol_id == tracked_symbol);
      core_price <= mac_pkg::PRICE_BITS'(tick.last_price);
      core_bid   <= tick.bid_price;
      core_ask   <= tick.ask_price;
    end
  end

  // ring memory, old data on a read of the entry being written
  assign ring_raddr = core_phase ? short_addr : long_addr;
  assign ring_we    = core_valid && core_phase && core_match;

  always_ff @(posedge clk) begin
    ring_rdata <= ring[ring_raddr];
    if (ring_we) begin
      ring[write_slot] <= core_price;
    end
  end

  // phase one: long sum update, fill count and slot advance
  always_comb begin
    long_window_sum_next = long_window_sum + mac_pkg::SUM_BITS'(core_price);
    if (fill_count >= lp) begin
      long_window_sum_next = long_window_sum_next - mac_pkg::SUM_BITS'(ring_rdata);
    end
    fill_count_next = fill_count;
    if (fill_count < lp) begin
      fill_count_next = fill_count + mac_pkg::PERIOD_BITS'(1);
    end
  end

  // short sum update, in the cycle after phase one
  always_comb begin
    short_window_sum_next = short_window_sum + mac_pkg::SUM_BITS'(s2_price);
    if (s2_sub) begin
      short_window_sum_next = short_window_sum_next - mac_pkg::SUM_BITS'(ring_rdata);
    end
  end

  // history registers
  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      fill_count       <= '0;
      write_slot       <= '0;
      long_window_sum  <= '0;
      short_window_sum <= '0;
    end else begin
      if (ring_we) begin
        long_window_sum <= long_window_sum_next;
        fill_count      <= fill_count_next;
        if (write_slot == mac_pkg::SLOT_BITS'(mac_pkg::MAX_WINDOW - 1)) begin
          write_slot <= '0;
        end else begin
          write_slot <= write_slot + mac_pkg::SLOT_BITS'(1);
        end
      end
      if (s2_valid && s2_match) begin
        short_window_sum <= short_window_sum_next;
      end
    end
  end

  // pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s2_valid <= core_valid && core_phase;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    s2_match <= core_match;
    s2_sub   <= core_match && (fill_count >= sp);
    s2_full  <= fill_count_next >= lp;
    s2_price <= core_price;
    s2_bid   <= core_bid;
    s2_ask   <= core_ask;

    s3_go    <= s2_match && s2_full;
    s3_short <= short_window_sum_next;
    s3_long  <= long_window_sum;
    s3_bid   <= s2_bid;
    s3_ask   <= s2_ask;

    s4_go         <= s3_go;
    s4_prod_short <= mac_pkg::PROD_BITS'(s3_short) * mac_pkg::PROD_BITS'(lp);
    s4_prod_long  <= mac_pkg::PROD_BITS'(s3_long) * mac_pkg::PROD_BITS'(sp);
    s4_bid        <= s3_bid;
    s4_ask        <= s3_ask;
  end

  // crossing detection
  always_comb begin
    above            = s4_prod_short > s4_prod_long;
    emit             = s4_valid && s4_go && (above != was_above);
    emit_order.side  = above ? mac_pkg::SIDE_BUY : mac_pkg::SIDE_SELL;
    emit_order.price = above ? s4_ask : s4_bid;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      was_above <= 1'b0;
    end else if (s4_valid && s4_go) begin
      was_above <= above;
    end
  end

  // order queue
  assign pop               = order.valid && order.ready;
  assign drop              = s4_valid && !emit;
  assign order.valid       = queue_count != '0;
  assign order.order_side  = queue[queue_head].side;
  assign order.order_price = queue[queue_head].price;

  always_ff @(posedge clk) begin
    if (emit) begin
      queue[queue_tail] <= emit_order;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      queue_head  <= '0;
      queue_tail  <= '0;
      queue_count <= '0;
      occupancy   <= '0;
    end else begin
      if (emit) begin
        queue_tail <= queue_tail + mac_pkg::QUEUE_PTR_BITS'(1);
      end
      if (pop) begin
        queue_head <= queue_head + mac_pkg::QUEUE_PTR_BITS'(1);
      end
      queue_count <= queue_count + mac_pkg::OCC_BITS'(emit) - mac_pkg::OCC_BITS'(pop);
      occupancy   <= occupancy + mac_pkg::OCC_BITS'(tick_accept)
                     - mac_pkg::OCC_BITS'(pop) - mac_pkg::OCC_BITS'(drop);
    end
  end

endmodule

@@ dv/moving_average_crossover_tb.sv @@
// testbench for the moving average crossover block: tick stimulus, order checking
`timescale 1ns / 1ps

module moving_average_crossover_tb;
  import mac_pkg::*;

  localparam int TIMEOUT_NS    = 2_000_000;
  localparam int SETTLE_CYCLES = 20;
  localparam int UNUSED_REG    = 3;

  // expected orders worked out from the accepted ticks
  class crossover_scoreboard;
    logic [SYMBOL_BITS-1:0]     symbol;
    logic [CFG_PERIOD_BITS-1:0] short_cfg;
    logic [CFG_PERIOD_BITS-1:0] long_cfg;
    logic [PRICE_BITS-1:0]      hist [MAX_WINDOW];
    int unsigned                filled;
    int unsigned                slot;
    logic [63:0]                short_sum;
    logic [63:0]                long_sum;
    bit                         above_prev;
    order_t                     orders [$];
    int unsigned                errors;
    int unsigned                tracked_ticks;
    int unsigned                ignored_ticks;
    int unsigned                buy_count;
    int unsigned                sell_count;

    function new();
      symbol    = SYMBOL_RESET;
      short_cfg = SHORT_RESET;
      long_cfg  = LONG_RESET;
      clear_history();
    endfunction

    function void clear_history();
      filled     = 0;
      slot       = 0;
      short_sum  = '0;
      long_sum   = '0;
      above_prev = 1'b0;
    endfunction

    // register write, any known register restarts the windows
    function void write_reg(int idx, logic [DATA_BITS-1:0] value);
      case (idx)
        REG_SYMBOL: symbol = value[SYMBOL_BITS-1:0];
        REG_SHORT:  short_cfg = value[CFG_PERIOD_BITS-1:0];
        REG_LONG:   long_cfg = value[CFG_PERIOD_BITS-1:0];
        default:    return;
      endcase
      clear_history();
    endfunction

    // one accepted tick transaction
    function void note_tick(logic [SYMBOL_BITS-1:0] sym, logic [FIELD_BITS-1:0] last,
                            logic [FIELD_BITS-1:0] bid, logic [FIELD_BITS-1:0] ask);
      int unsigned           lp;
      int unsigned           sp;
      logic [PRICE_BITS-1:0] price;
      logic [63:0]           lhs;
      logic [63:0]           rhs;
      bit                    above;
      order_t                item;
      if (sym != symbol) begin
        ignored_ticks++;
        return;
      end
      tracked_ticks++;
      // clamp the periods
      lp = long_cfg;
      if (lp < 1) lp = 1;
      if (lp > MAX_WINDOW) lp = MAX_WINDOW;
      sp = short_cfg;
      if (sp < 1) sp = 1;
      if (sp > lp) sp = lp;
      price = last[PRICE_BITS-1:0];
      // slide both windows
      if (filled >= lp) long_sum -= hist[(slot + MAX_WINDOW - lp) % MAX_WINDOW];
      if (filled >= sp) short_sum -= hist[(slot + MAX_WINDOW - sp) % MAX_WINDOW];
      long_sum += price;
      short_sum += price;
      hist[slot] = price;
      slot = (slot + 1) % MAX_WINDOW;
      if (filled < lp) filled++;
      if (filled < lp) return;
      // short mean above long mean, by cross-multiplication
      lhs = short_sum * lp;
      rhs = long_sum * sp;
      above = lhs > rhs;
      if (above && !above_prev) begin
        above_prev = 1'b1;
        item.side  = SIDE_BUY;
        item.price = ask;
        orders.insert(orders.size(), item);
        buy_count++;
      end else if (!above && above_prev) begin
        above_prev = 1'b0;
        item.side  = SIDE_SELL;
        item.price = bid;
        orders.insert(orders.size(), item);
        sell_count++;
      end
    endfunction

    // one accepted order transaction against the oldest expectation
    function void check_order(logic side, logic [FIELD_BITS-1:0] price);
      order_t want;
      if (orders.size() == 0) begin
        $display("%0t: unexpected order, side %0b price %0h", $time, side, price);
        errors++;
        return;
      end
      want = orders[0];
      orders.delete(0);
      if (side !== want.side) begin
        $display("%0t: order side mismatch, expected %0b, got %0b", $time, want.side, side);
        errors++;
      end
      if (price !== want.price) begin
        $display("%0t: order price mismatch, expected %0h, got %0h",
                 $time, want.price, price);
        errors++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [DATA_BITS-1:0] pwdata;
  logic [DATA_BITS-1:0] prdata;
  logic                 pready;

  mac_tick_if  tick_ch();
  mac_order_if order_ch();

  crossover_scoreboard sb;
  bit                  no_idle;
  logic [FIELD_BITS-1:0] cur_price;
  int unsigned         step_max;
  int unsigned         settings_used;

  moving_average_crossover dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .order   (order_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  initial begin
    #TIMEOUT_NS;
    $display("moving_average_crossover_tb NOT OK");
    $finish;
  end

  // monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (tick_ch.valid && tick_ch.ready)
        sb.note_tick(tick_ch.symbol_id, tick_ch.last_price, tick_ch.bid_price,
                     tick_ch.ask_price);
      if (order_ch.valid && order_ch.ready)
        sb.check_order(order_ch.order_side, order_ch.order_price);
    end
  end

  // order sink with random stalls
  initial begin
    int unsigned stall;
    order_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall != 0) begin
        order_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      order_ch.ready <= 1'b1;
      do @(posedge clk); while (!order_ch.valid);
    end
  end

  // register write over the apb port
  task automatic apb_write(input int idx, input logic [DATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_BITS'(idx * 4);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, value);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // one tick transaction, after a random gap
  task automatic send_tick(input logic [SYMBOL_BITS-1:0] sym, input logic [FIELD_BITS-1:0] last,
                           input logic [FIELD_BITS-1:0] bid, input logic [FIELD_BITS-1:0] ask);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid      <= 1'b1;
    tick_ch.symbol_id  <= sym;
    tick_ch.last_price <= last;
    tick_ch.bid_price  <= bid;
    tick_ch.ask_price  <= ask;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  // hold the tick side until every expected order is out
  task automatic wait_for_orders(input int unsigned settle);
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (sb.orders.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  // random walk of the trade price, with rare jumps to the extremes and to random prices
  function automatic logic [FIELD_BITS-1:0] walk_price(logic [FIELD_BITS-1:0] cur,
                                                       int unsigned span);
    int unsigned pick;
    longint      nxt;
    pick = $urandom_range(0, 39);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    if (pick == 2) return $urandom;
    nxt = longint'(cur) + longint'($urandom_range(0, 2 * span)) - longint'(span);
    if (nxt < 0) nxt = 0;
    if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
    return nxt[FIELD_BITS-1:0];
  endfunction

  // random ticks for the tracked symbol, mixed with other symbols
  task automatic run_random(input int unsigned n_ticks, input bit hold_once);
    int unsigned            i;
    int unsigned            hold_at;
    logic [SYMBOL_BITS-1:0] sym;
    hold_at = hold_once ? n_ticks / 2 : n_ticks + 1;
    for (i = 0; i < n_ticks; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      cur_price = walk_price(cur_price, step_max);
      sym = sb.symbol;
      if ($urandom_range(0, 6) == 0)
        sym = $urandom_range(0, 1) ? 16'($urandom) : sym ^ (16'h1 << $urandom_range(0, 15));
      send_tick(sym, cur_price, $urandom, $urandom);
      if (i == hold_at) wait_for_orders(0);
    end
  endtask

  initial begin
    int unsigned            ph;
    int unsigned            n_ticks;
    logic [SYMBOL_BITS-1:0] sym;
    logic [CFG_PERIOD_BITS-1:0] sp;
    logic [CFG_PERIOD_BITS-1:0] lp;
    sb = new();
    no_idle            = 1'b0;
    settings_used      = 1;
    rst                <= 1'b1;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    tick_ch.valid      <= 1'b0;
    tick_ch.symbol_id  <= '0;
    tick_ch.last_price <= '0;
    tick_ch.bid_price  <= '0;
    tick_ch.ask_price  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // opening phase under the reset-time registers
    step_max  = 1000;
    cur_price = $urandom;
    run_random(120, 1'b1);
    wait_for_orders(SETTLE_CYCLES);

    // directed: one-tick short window against a two-tick long window
    apb_write(REG_SYMBOL, 32'h0000_FFFF);
    apb_write(REG_SHORT, 32'd1);
    apb_write(REG_LONG, 32'd2);
    settings_used++;
    send_tick(16'hFFFF, 32'h0, $urandom, $urandom);            // warm-up, no order
    send_tick(16'hFFFF, 32'h0, $urandom, $urandom);            // equal means
    send_tick(16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);  // upward cross
    wait_for_orders(SETTLE_CYCLES);
    // a write to an unused address keeps the history
    apb_write(UNUSED_REG, 32'hFFFF_FFFF);
    send_tick(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);  // equal, downward cross
    send_tick(16'h0000, 32'h0, $urandom, $urandom);            // other symbol
    send_tick(16'hFFFE, 32'hFFFF_FFFF, $urandom, $urandom);    // near-miss symbol
    send_tick(16'hFFFF, 32'h0, $urandom, $urandom);
    send_tick(16'hFFFF, 32'h1, $urandom, 32'h0);               // buy at zero ask
    send_tick(16'hFFFF, 32'h2, $urandom, $urandom);            // still above
    send_tick(16'hFFFF, 32'h1, 32'h0, $urandom);               // sell at zero bid
    send_tick(16'hFFFF, 32'h8000_0000, $urandom, 32'h5555_AAAA);
    send_tick(16'hFFFF, 32'h7FFF_FFFF, 32'hAAAA_5555, $urandom);
    wait_for_orders(SETTLE_CYCLES);

    // random phases, clamped and extreme periods first
    for (ph = 0; ph < 15; ph++) begin
      sym = (ph == 0) ? 16'h0000 : (ph == 1) ? 16'hFFFF : 16'($urandom);
      case (ph)
        0: begin sp = 7'd0;   lp = 7'd0;   end
        1: begin sp = 7'd64;  lp = 7'd64;  end
        2: begin sp = 7'd3;   lp = 7'd64;  end
        3: begin sp = 7'd127; lp = 7'd10;  end
        4: begin sp = 7'd1;   lp = 7'd127; end
        5: begin sp = 7'd2;   lp = 7'd65;  end
        6: begin sp = 7'd0;   lp = 7'd7;   end
        default: begin
          sp = 7'($urandom_range(1, 8));
          lp = 7'($urandom_range(sp + 1, sp + 20));
        end
      endcase
      case ($urandom_range(0, 3))
        0: step_max = 3;
        1: step_max = 100;
        2: step_max = 100_000;
        default: step_max = 50_000_000;
      endcase
      cur_price = (ph == 5) ? 32'hFFFF_FF00 : $urandom;
      apb_write(REG_SYMBOL, {16'($urandom), sym});
      apb_write(REG_SHORT, {25'($urandom), sp});
      apb_write(REG_LONG, {25'($urandom), lp});
      if ($urandom_range(0, 3) == 0) apb_write(UNUSED_REG, $urandom);
      settings_used++;
      n_ticks = (ph == 0 || ph == 1 || ph == 3) ? 40 : $urandom_range(110, 180);
      run_random(n_ticks, $urandom_range(0, 3) == 0);
      wait_for_orders(SETTLE_CYCLES);
    end

    $display("covered %0d tracked and %0d ignored ticks over %0d register settings,",
             sb.tracked_ticks, sb.ignored_ticks, settings_used);
    $display("with %0d buy and %0d sell orders checked", sb.buy_count, sb.sell_count);
    if (sb.errors == 0)
      $display("moving_average_crossover_tb OK");
    else
      $display("moving_average_crossover_tb NOT OK");
    $finish;
  end

endmodule
